>>> hw/rtl/hpack_huffman_string_encoder_core_defines.svh
// Assertion macros shared by the encoder RTL
`ifndef HPACK_HUFFMAN_STRING_ENCODER_CORE_DEFINES_SVH
`define HPACK_HUFFMAN_STRING_ENCODER_CORE_DEFINES_SVH
// check that a condition implies a consequence in the same cycle
`define HH_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("lbl failed");
// check that a condition implies a consequence in the next cycle
`define HH_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("lbl failed");
`endif

>>> hw/rtl/hh_pkg.sv
// Package: Huffman code table, queue entry type and constants for the encoder
package hh_pkg;

    localparam int QDepth = 4;
    localparam int QPtrW  = 2;

    typedef struct packed {
        logic [29:0] code;
        logic [4:0]  len;
        logic        last;
    } hh_entry_t;

    function automatic logic [29:0] hh_code(input logic [7:0] s);
        logic [29:0] c;
        begin
            case (s)
            8'd0: c = 30'h1ff8; 8'd1: c = 30'h7fffd8; 8'd2: c = 30'hfffffe2;
            8'd3: c = 30'hfffffe3; 8'd4: c = 30'hfffffe4; 8'd5: c = 30'hfffffe5;
            8'd6: c = 30'hfffffe6; 8'd7: c = 30'hfffffe7; 8'd8: c = 30'hfffffe8;
            8'd9: c = 30'hffffea; 8'd10: c = 30'h3ffffffc; 8'd11: c = 30'hfffffe9;
            8'd12: c = 30'hfffffea; 8'd13: c = 30'h3ffffffd; 8'd14: c = 30'hfffffeb;
            8'd15: c = 30'hfffffec; 8'd16: c = 30'hfffffed; 8'd17: c = 30'hfffffee;
            8'd18: c = 30'hfffffef; 8'd19: c = 30'hffffff0; 8'd20: c = 30'hffffff1;
            8'd21: c = 30'hffffff2; 8'd22: c = 30'h3ffffffe; 8'd23: c = 30'hffffff3;
            8'd24: c = 30'hffffff4; 8'd25: c = 30'hffffff5; 8'd26: c = 30'hffffff6;
            8'd27: c = 30'hffffff7; 8'd28: c = 30'hffffff8; 8'd29: c = 30'hffffff9;
            8'd30: c = 30'hffffffa; 8'd31: c = 30'hffffffb;
            8'd32: c = 30'h14; 8'd33: c = 30'h3f8; 8'd34: c = 30'h3f9; 8'd35: c = 30'hffa;
            8'd36: c = 30'h1ff9; 8'd37: c = 30'h15; 8'd38: c = 30'hf8; 8'd39: c = 30'h7fa;
            8'd40: c = 30'h3fa; 8'd41: c = 30'h3fb; 8'd42: c = 30'hf9; 8'd43: c = 30'h7fb;
            8'd44: c = 30'hfa; 8'd45: c = 30'h16; 8'd46: c = 30'h17; 8'd47: c = 30'h18;
            8'd48: c = 30'h0; 8'd49: c = 30'h1; 8'd50: c = 30'h2; 8'd51: c = 30'h19;
            8'd52: c = 30'h1a; 8'd53: c = 30'h1b; 8'd54: c = 30'h1c; 8'd55: c = 30'h1d;
            8'd56: c = 30'h1e; 8'd57: c = 30'h1f; 8'd58: c = 30'h5c; 8'd59: c = 30'hfb;
            8'd60: c = 30'h7ffc; 8'd61: c = 30'h20; 8'd62: c = 30'hffb; 8'd63: c = 30'h3fc;
            8'd64: c = 30'h1ffa; 8'd65: c = 30'h21; 8'd66: c = 30'h5d; 8'd67: c = 30'h5e;
            8'd68: c = 30'h5f; 8'd69: c = 30'h60; 8'd70: c = 30'h61; 8'd71: c = 30'h62;
            8'd72: c = 30'h63; 8'd73: c = 30'h64; 8'd74: c = 30'h65; 8'd75: c = 30'h66;
            8'd76: c = 30'h67; 8'd77: c = 30'h68; 8'd78: c = 30'h69; 8'd79: c = 30'h6a;
            8'd80: c = 30'h6b; 8'd81: c = 30'h6c; 8'd82: c = 30'h6d; 8'd83: c = 30'h6e;
            8'd84: c = 30'h6f; 8'd85: c = 30'h70; 8'd86: c = 30'h71; 8'd87: c = 30'h72;
            8'd88: c = 30'hfc; 8'd89: c = 30'h73; 8'd90: c = 30'hfd; 8'd91: c = 30'h1ffb;
            8'd92: c = 30'h7fff0; 8'd93: c = 30'h1ffc; 8'd94: c = 30'h3ffc; 8'd95: c = 30'h22;
            8'd96: c = 30'h7ffd; 8'd97: c = 30'h3; 8'd98: c = 30'h23; 8'd99: c = 30'h4;
            8'd100: c = 30'h24; 8'd101: c = 30'h5; 8'd102: c = 30'h25; 8'd103: c = 30'h26;
            8'd104: c = 30'h27; 8'd105: c = 30'h6; 8'd106: c = 30'h74; 8'd107: c = 30'h75;
            8'd108: c = 30'h28; 8'd109: c = 30'h29; 8'd110: c = 30'h2a; 8'd111: c = 30'h7;
            8'd112: c = 30'h2b; 8'd113: c = 30'h76; 8'd114: c = 30'h2c; 8'd115: c = 30'h8;
            8'd116: c = 30'h9; 8'd117: c = 30'h2d; 8'd118: c = 30'h77; 8'd119: c = 30'h78;
            8'd120: c = 30'h79; 8'd121: c = 30'h7a; 8'd122: c = 30'h7b; 8'd123: c = 30'h7ffe;
            8'd124: c = 30'h7fc; 8'd125: c = 30'h3ffd; 8'd126: c = 30'h1ffd;
            8'd127: c = 30'hffffffc;
            8'd128: c = 30'hfffe6; 8'd129: c = 30'h3fffd2; 8'd130: c = 30'hfffe7;
            8'd131: c = 30'hfffe8; 8'd132: c = 30'h3fffd3; 8'd133: c = 30'h3fffd4;
            8'd134: c = 30'h3fffd5; 8'd135: c = 30'h7fffd9; 8'd136: c = 30'h3fffd6;
            8'd137: c = 30'h7fffda; 8'd138: c = 30'h7fffdb; 8'd139: c = 30'h7fffdc;
            8'd140: c = 30'h7fffdd; 8'd141: c = 30'h7fffde; 8'd142: c = 30'hffffeb;
            8'd143: c = 30'h7fffdf; 8'd144: c = 30'hffffec; 8'd145: c = 30'hffffed;
            8'd146: c = 30'h3fffd7; 8'd147: c = 30'h7fffe0; 8'd148: c = 30'hffffee;
            8'd149: c = 30'h7fffe1; 8'd150: c = 30'h7fffe2; 8'd151: c = 30'h7fffe3;
            8'd152: c = 30'h7fffe4; 8'd153: c = 30'h1fffdc; 8'd154: c = 30'h3fffd8;
            8'd155: c = 30'h7fffe5; 8'd156: c = 30'h3fffd9; 8'd157: c = 30'h7fffe6;
            8'd158: c = 30'h7fffe7; 8'd159: c = 30'hffffef; 8'd160: c = 30'h3fffda;
            8'd161: c = 30'h1fffdd; 8'd162: c = 30'hfffe9; 8'd163: c = 30'h3fffdb;
            8'd164: c = 30'h3fffdc; 8'd165: c = 30'h7fffe8; 8'd166: c = 30'h7fffe9;
            8'd167: c = 30'h1fffde; 8'd168: c = 30'h7fffea; 8'd169: c = 30'h3fffdd;
            8'd170: c = 30'h3fffde; 8'd171: c = 30'hfffff0; 8'd172: c = 30'h1fffdf;
            8'd173: c = 30'h3fffdf; 8'd174: c = 30'h7fffeb; 8'd175: c = 30'h7fffec;
            8'd176: c = 30'h1fffe0; 8'd177: c = 30'h1fffe1; 8'd178: c = 30'h3fffe0;
            8'd179: c = 30'h1fffe2; 8'd180: c = 30'h7fffed; 8'd181: c = 30'h3fffe1;
            8'd182: c = 30'h7fffee; 8'd183: c = 30'h7fffef; 8'd184: c = 30'hfffea;
            8'd185: c = 30'h3fffe2; 8'd186: c = 30'h3fffe3; 8'd187: c = 30'h3fffe4;
            8'd188: c = 30'h7ffff0; 8'd189: c = 30'h3fffe5; 8'd190: c = 30'h3fffe6;
            8'd191: c = 30'h7ffff1; 8'd192: c = 30'h3ffffe0; 8'd193: c = 30'h3ffffe1;
            8'd194: c = 30'hfffeb; 8'd195: c = 30'h7fff1; 8'd196: c = 30'h3fffe7;
            8'd197: c = 30'h7ffff2; 8'd198: c = 30'h3fffe8; 8'd199: c = 30'h1ffffec;
            8'd200: c = 30'h3ffffe2; 8'd201: c = 30'h3ffffe3; 8'd202: c = 30'h3ffffe4;
            8'd203: c = 30'h7ffffde; 8'd204: c = 30'h7ffffdf; 8'd205: c = 30'h3ffffe5;
            8'd206: c = 30'hfffff1; 8'd207: c = 30'h1ffffed; 8'd208: c = 30'h7fff2;
            8'd209: c = 30'h1fffe3; 8'd210: c = 30'h3ffffe6; 8'd211: c = 30'h7ffffe0;
            8'd212: c = 30'h7ffffe1; 8'd213: c = 30'h3ffffe7; 8'd214: c = 30'h7ffffe2;
            8'd215: c = 30'hfffff2; 8'd216: c = 30'h1fffe4; 8'd217: c = 30'h1fffe5;
            8'd218: c = 30'h3ffffe8; 8'd219: c = 30'h3ffffe9; 8'd220: c = 30'hffffffd;
            8'd221: c = 30'h7ffffe3; 8'd222: c = 30'h7ffffe4; 8'd223: c = 30'h7ffffe5;
            8'd224: c = 30'hfffec; 8'd225: c = 30'hfffff3; 8'd226: c = 30'hfffed;
            8'd227: c = 30'h1fffe6; 8'd228: c = 30'h3fffe9; 8'd229: c = 30'h1fffe7;
            8'd230: c = 30'h1fffe8; 8'd231: c = 30'h7ffff3; 8'd232: c = 30'h3fffea;
            8'd233: c = 30'h3fffeb; 8'd234: c = 30'h1ffffee; 8'd235: c = 30'h1ffffef;
            8'd236: c = 30'hfffff4; 8'd237: c = 30'hfffff5; 8'd238: c = 30'h3ffffea;
            8'd239: c = 30'h7ffff4; 8'd240: c = 30'h3ffffeb; 8'd241: c = 30'h7ffffe6;
            8'd242: c = 30'h3ffffec; 8'd243: c = 30'h3ffffed; 8'd244: c = 30'h7ffffe7;
            8'd245: c = 30'h7ffffe8; 8'd246: c = 30'h7ffffe9; 8'd247: c = 30'h7ffffea;
            8'd248: c = 30'h7ffffeb; 8'd249: c = 30'hffffffe; 8'd250: c = 30'h7ffffec;
            8'd251: c = 30'h7ffffed; 8'd252: c = 30'h7ffffee; 8'd253: c = 30'h7ffffef;
            8'd254: c = 30'h7fffff0; 8'd255: c = 30'h3ffffee;
            default: c = 30'h0;
            endcase
            return c;
        end
    endfunction

    localparam logic [4:0] HcLen [256] = '{
        5'd13,5'd23,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,
        5'd28,5'd24,5'd30,5'd28,5'd28,5'd30,5'd28,5'd28,
        5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd30,5'd28,
        5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,
        5'd6,5'd10,5'd10,5'd12,5'd13,5'd6,5'd8,5'd11,
        5'd10,5'd10,5'd8,5'd11,5'd8,5'd6,5'd6,5'd6,
        5'd5,5'd5,5'd5,5'd6,5'd6,5'd6,5'd6,5'd6,
        5'd6,5'd6,5'd7,5'd8,5'd15,5'd6,5'd12,5'd10,
        5'd13,5'd6,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,
        5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,
        5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,
        5'd8,5'd7,5'd8,5'd13,5'd19,5'd13,5'd14,5'd6,
        5'd15,5'd5,5'd6,5'd5,5'd6,5'd5,5'd6,5'd6,
        5'd6,5'd5,5'd7,5'd7,5'd6,5'd6,5'd6,5'd5,
        5'd6,5'd7,5'd6,5'd5,5'd5,5'd6,5'd7,5'd7,
        5'd7,5'd7,5'd7,5'd15,5'd11,5'd14,5'd13,5'd28,
        5'd20,5'd22,5'd20,5'd20,5'd22,5'd22,5'd22,5'd23,
        5'd22,5'd23,5'd23,5'd23,5'd23,5'd23,5'd24,5'd23,
        5'd24,5'd24,5'd22,5'd23,5'd24,5'd23,5'd23,5'd23,
        5'd23,5'd21,5'd22,5'd23,5'd22,5'd23,5'd23,5'd24,
        5'd22,5'd21,5'd20,5'd22,5'd22,5'd23,5'd23,5'd21,
        5'd23,5'd22,5'd22,5'd24,5'd21,5'd22,5'd23,5'd23,
        5'd21,5'd21,5'd22,5'd21,5'd23,5'd22,5'd23,5'd23,
        5'd20,5'd22,5'd22,5'd22,5'd23,5'd22,5'd22,5'd23,
        5'd26,5'd26,5'd20,5'd19,5'd22,5'd23,5'd22,5'd25,
        5'd26,5'd26,5'd26,5'd27,5'd27,5'd26,5'd24,5'd25,
        5'd19,5'd21,5'd26,5'd27,5'd27,5'd26,5'd27,5'd24,
        5'd21,5'd21,5'd26,5'd26,5'd28,5'd27,5'd27,5'd27,
        5'd20,5'd24,5'd20,5'd21,5'd22,5'd21,5'd21,5'd23,
        5'd22,5'd22,5'd25,5'd25,5'd24,5'd24,5'd26,5'd23,
        5'd26,5'd27,5'd26,5'd26,5'd27,5'd27,5'd27,5'd27,
        5'd27,5'd28,5'd27,5'd27,5'd27,5'd27,5'd27,5'd26
    };

endpackage

>>> hw/rtl/hh_front.sv
// Front end: accept string bytes, look up Huffman codes, fill the code queue
module hh_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             valid,
    output logic             ready,
    input  logic [7:0]       symbol,
    input  logic             last_symbol,
    output logic             q_valid,
    input  logic             q_ready,
    output hh_pkg::hh_entry_t q_entry
);
    import hh_pkg::*;

    hh_entry_t mem_reg [QDepth];
    logic [QPtrW:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPtrW:0] fill;
    logic push, pop;

    assign fill    = wr_ptr_reg - rd_ptr_reg;
    assign ready   = (fill != (QPtrW+1)'(QDepth));
    assign q_valid = (fill != '0);
    assign push    = valid && ready;
    assign pop     = q_valid && q_ready;
    assign q_entry = mem_reg[rd_ptr_reg[QPtrW-1:0]];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg[QPtrW-1:0]] <= '{code: hh_code(symbol),
                                                len: HcLen[symbol],
                                                last: last_symbol};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

`include "hpack_huffman_string_encoder_core_defines.svh"
    `HH_ASSERT_IMP(a_no_overfill, 1'b1, fill <= (QPtrW+1)'(QDepth))
    `HH_ASSERT_NEXT(a_push_fills, push && !pop, fill == $past(fill) + 1'b1)
    `HH_ASSERT_NEXT(a_pop_drains, pop && !push, fill == $past(fill) - 1'b1)
endmodule

>>> hw/rtl/hh_back.sv
// Back end: pack queued codes into bytes, pad and count at string end
module hh_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_ready,
    input  hh_pkg::hh_entry_t q_entry,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic             last_byte,
    output logic [15:0]      total_bytes
);
    import hh_pkg::*;

    // acc holds up to 7 pending bits plus one code of at most 30 bits
    logic [36:0] acc_reg, acc_next;
    logic [5:0]  n_reg, n_next;
    logic        busy_reg, busy_next;
    logic        last_reg, last_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [7:0]  ob_reg, ob_next;
    logic        ol_reg, ol_next;
    logic [15:0] ot_reg, ot_next;
    logic        ov_reg, ov_next;
    logic        slot_free;
    logic        emit;
    logic [7:0]  byte_v;
    logic        final_v;
    logic [15:0] cnt_inc;
    logic [36:0] shifted;
    logic [5:0]  sh;

    assign slot_free = !ov_reg || out_ready;
    assign q_ready   = !busy_reg && slot_free;
    assign cnt_inc   = (cnt_reg == 16'hFFFF) ? cnt_reg : cnt_reg + 16'd1;
    assign sh        = (n_reg >= 6'd8) ? n_reg - 6'd8 : 6'd0;
    assign shifted   = acc_reg >> sh;

    always_comb
    begin
        acc_next  = acc_reg;
        n_next    = n_reg;
        busy_next = busy_reg;
        last_next = last_reg;
        cnt_next  = cnt_reg;
        ob_next   = ob_reg;
        ol_next   = ol_reg;
        ot_next   = ot_reg;
        ov_next   = ov_reg && !out_ready;
        emit      = 1'b0;
        byte_v    = 8'h00;
        final_v   = 1'b0;
        if (busy_reg && slot_free)
        begin
            if (n_reg >= 6'd8)
            begin
                emit    = 1'b1;
                byte_v  = shifted[7:0];
                n_next  = n_reg - 6'd8;
                final_v = last_reg && (n_reg == 6'd8);
            end
            else if (last_reg && n_reg != 6'd0)
            begin
                emit    = 1'b1;
                byte_v  = (acc_reg[7:0] << (6'd8 - n_reg)) | (8'hFF >> n_reg[2:0]);
                n_next  = 6'd0;
                final_v = 1'b1;
            end
            if (emit)
            begin
                ov_next  = 1'b1;
                ob_next  = byte_v;
                ol_next  = final_v;
                ot_next  = final_v ? cnt_inc : 16'd0;
                cnt_next = final_v ? 16'd0 : cnt_inc;
            end
            if (n_next < 6'd8 && !(last_reg && n_next != 6'd0))
            begin
                busy_next = 1'b0;
                if (last_reg)
                begin
                    acc_next = '0;
                    n_next   = 6'd0;
                    // last symbol with no byte: count returns to zero
                    cnt_next = 16'd0;
                end
            end
        end
        else if (q_valid && q_ready)
        begin
            acc_next  = ({30'd0, acc_reg[6:0]} << q_entry.len)
                        | {7'd0, q_entry.code};
            n_next    = n_reg + {1'b0, q_entry.len};
            last_next = q_entry.last;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            n_reg    <= '0;
            busy_reg <= 1'b0;
            last_reg <= 1'b0;
            cnt_reg  <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            n_reg    <= n_next;
            busy_reg <= busy_next;
            last_reg <= last_next;
            cnt_reg  <= cnt_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ob_reg <= ob_next;
        ol_reg <= ol_next;
        ot_reg <= ot_next;
    end

    assign out_valid   = ov_reg;
    assign out_byte    = ob_reg;
    assign last_byte   = ol_reg;
    assign total_bytes = ot_reg;

`include "hpack_huffman_string_encoder_core_defines.svh"
    `HH_ASSERT_IMP(a_idle_short, !busy_reg, n_reg < 6'd8)
    `HH_ASSERT_NEXT(a_hold_out, out_valid && !out_ready, out_valid && $stable(out_byte))
    `HH_ASSERT_IMP(a_total_on_last, out_valid && !last_byte, total_bytes == 16'd0)
endmodule

>>> hw/rtl/hpack_huffman_string_encoder_core.sv
// Top level: HPACK static Huffman string encoder
//
// Input channel (valid/ready): one string byte per item in symbol, with
// last_symbol high on the final byte of the string. Output channel
// (out_valid/out_ready): one coded byte per item in out_byte, earliest code
// bit in the MSB; last_byte marks the string's final coded byte and
// total_bytes then carries the byte count of the string (saturating at
// 65535, zero on other bytes).
// The front end looks up each code and writes it into a four-entry queue;
// the back end appends it to the bit accumulator and then emits one byte a
// cycle while the receiver accepts bytes. Each symbol is loaded into the
// accumulator; the back end then emits each completed byte, and at string
// end the padding byte, before it takes the next code. Input is taken
// every cycle while the queue has room. An input byte's code passes through
// the queue, the accumulator and the output register on its way out.
// Reset clears the queue, the accumulator and the byte count. A stalled
// receiver holds the output register; the back end stops and the queue
// fills, after which ready falls.
module hpack_huffman_string_encoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        ready,
    input  logic [7:0]  symbol,
    input  logic        last_symbol,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last_byte,
    output logic [15:0] total_bytes
);
    import hh_pkg::*;

    logic      q_valid, q_ready;
    hh_entry_t q_entry;

    hh_front u_front (
        .clk(clk), .rst_n(rst_n), .valid(valid), .ready(ready),
        .symbol(symbol), .last_symbol(last_symbol),
        .q_valid(q_valid), .q_ready(q_ready), .q_entry(q_entry)
    );

    hh_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
        .q_entry(q_entry), .out_valid(out_valid), .out_ready(out_ready),
        .out_byte(out_byte), .last_byte(last_byte), .total_bytes(total_bytes)
    );
endmodule
